>>> rtl/core/gdbd_pkg.sv
package gdbd_pkg;

	localparam int YEAR_W  = 14;
	localparam int MONTH_W = 4;
	localparam int DAY_W   = 5;
	localparam int COUNT_W = 23;
	localparam int STAT_W  = 2;

	// year shifted by 400 so the day number never goes negative; one more bit
	localparam int YY_W    = YEAR_W + 1;
	// quotient by 100 of a YY_W-bit value
	localparam int Q100_W  = 8;
	localparam int MOFF_W  = 9;
	localparam int DNUM_W  = 23;

	// x / 100 == (x * 5243) >> 19 for all x below 43690
	localparam int Q100_MUL   = 5243;
	localparam int Q100_SHIFT = 19;
	localparam int Q100_PW    = 28;

	localparam logic [COUNT_W-1:0] COUNT_SAT = {1'b0, {(COUNT_W-1){1'b1}}};

	localparam logic [STAT_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STAT_W-1:0] STAT_ORDER   = 2'd1;
	localparam logic [STAT_W-1:0] STAT_INVALID = 2'd2;

	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

	// one date after the first stage
	typedef struct packed {
		logic [YEAR_W-1:0]  year;
		logic [YY_W-1:0]    yy;
		logic [Q100_W-1:0]  q100_y;
		logic [Q100_W-1:0]  q100_yy;
		logic [MOFF_W-1:0]  moff;
		logic [DAY_W-1:0]   mlen;
		logic               is_feb;
		logic               month_ok;
		logic [DAY_W-1:0]   day;
	} prep_t;

	// one date after the second stage
	typedef struct packed {
		logic              ok;
		logic [DNUM_W-1:0] dnum;
	} dnum_t;

	// days from March 1 to the first of the month, year starting in March
	function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
		logic [MOFF_W-1:0] r;
		case (m)
			4'd3:    r = 9'd0;
			4'd4:    r = 9'd31;
			4'd5:    r = 9'd61;
			4'd6:    r = 9'd92;
			4'd7:    r = 9'd122;
			4'd8:    r = 9'd153;
			4'd9:    r = 9'd184;
			4'd10:   r = 9'd214;
			4'd11:   r = 9'd245;
			4'd12:   r = 9'd275;
			4'd1:    r = 9'd306;
			4'd2:    r = 9'd337;
			default: r = 9'd0;
		endcase
		return r;
	endfunction

	// month length in a common year
	function automatic logic [DAY_W-1:0] month_length(input logic [MONTH_W-1:0] m);
		logic [DAY_W-1:0] r;
		case (m)
			4'd2:                     r = 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:  r = 5'd30;
			default:                  r = 5'd31;
		endcase
		return r;
	endfunction

endpackage

>>> rtl/core/gdbd_date_prep.sv
module gdbd_date_prep (
	input  logic [gdbd_pkg::YEAR_W-1:0]  year,
	input  logic [gdbd_pkg::MONTH_W-1:0] month,
	input  logic [gdbd_pkg::DAY_W-1:0]   day,
	output gdbd_pkg::prep_t              prep
);

	logic                          is_jf;
	logic [gdbd_pkg::YY_W-1:0]     yy;
	logic [gdbd_pkg::Q100_PW-1:0]  prod_y;
	logic [gdbd_pkg::Q100_PW-1:0]  prod_yy;

	// Jan and Feb belong to the previous March-based year
	assign is_jf   = (month <= gdbd_pkg::MONTH_FEB);
	assign yy      = gdbd_pkg::YY_W'(year) + gdbd_pkg::YY_W'(400)
	               - gdbd_pkg::YY_W'(is_jf);
	assign prod_y  = gdbd_pkg::Q100_PW'(year) * gdbd_pkg::Q100_PW'(gdbd_pkg::Q100_MUL);
	assign prod_yy = gdbd_pkg::Q100_PW'(yy) * gdbd_pkg::Q100_PW'(gdbd_pkg::Q100_MUL);

	always_comb begin
		prep.year     = year;
		prep.yy       = yy;
		prep.q100_y   = prod_y[gdbd_pkg::Q100_SHIFT +: gdbd_pkg::Q100_W];
		prep.q100_yy  = prod_yy[gdbd_pkg::Q100_SHIFT +: gdbd_pkg::Q100_W];
		prep.moff     = gdbd_pkg::month_offset(month);
		prep.mlen     = gdbd_pkg::month_length(month);
		prep.is_feb   = (month == gdbd_pkg::MONTH_FEB);
		prep.month_ok = (month != '0) && (month <= gdbd_pkg::MONTH_DEC);
		prep.day      = day;
	end

endmodule

>>> rtl/core/gdbd_date_num.sv
module gdbd_date_num (
	input  gdbd_pkg::prep_t prep,
	output gdbd_pkg::dnum_t num
);

	logic [gdbd_pkg::YEAR_W-1:0] rem100;
	logic                        leap;
	logic [gdbd_pkg::DAY_W-1:0]  mlen;

	assign rem100 = prep.year
	              - gdbd_pkg::YEAR_W'(gdbd_pkg::YEAR_W'(prep.q100_y) * gdbd_pkg::YEAR_W'(100));
	// div by 4 and not by 100, or div by 400
	assign leap   = ((prep.year[1:0] == 2'd0) && (rem100 != '0))
	             || ((rem100 == '0) && (prep.q100_y[1:0] == 2'd0));
	assign mlen   = (prep.is_feb && leap) ? gdbd_pkg::DAY_W'(29) : prep.mlen;

	always_comb begin
		num.ok   = prep.month_ok && (prep.day != '0) && (prep.day <= mlen);
		num.dnum = gdbd_pkg::DNUM_W'(gdbd_pkg::DNUM_W'(prep.yy) * gdbd_pkg::DNUM_W'(365))
		         + gdbd_pkg::DNUM_W'(prep.yy >> 2)
		         - gdbd_pkg::DNUM_W'(prep.q100_yy)
		         + gdbd_pkg::DNUM_W'(prep.q100_yy >> 2)
		         + gdbd_pkg::DNUM_W'(prep.moff)
		         + gdbd_pkg::DNUM_W'(prep.day)
		         - gdbd_pkg::DNUM_W'(1);
	end

endmodule

>>> rtl/core/gregorian_days_between_dates.sv
// Days between two proleptic Gregorian dates. Each beat on the input carries a
// start and an end date and yields one result beat from the last stage, and a new
// pair is taken every cycle while the output drains. The three register stages
// are: month tables and the divide-by-100 reciprocal products, then leap test,
// date check and day number of each date, then the ordered difference. Status 2
// (count 0) flags a bad month or day in either date, status 1 (count -1) a start
// not before the end. include_end_day adds one to a good count, which
// saturates at 4194303. Write cfg only while the pipeline is empty.
module gregorian_days_between_dates (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [gdbd_pkg::YEAR_W-1:0]         start_year,
	input  logic [gdbd_pkg::MONTH_W-1:0]        start_month,
	input  logic [gdbd_pkg::DAY_W-1:0]          start_day,
	input  logic [gdbd_pkg::YEAR_W-1:0]         end_year,
	input  logic [gdbd_pkg::MONTH_W-1:0]        end_month,
	input  logic [gdbd_pkg::DAY_W-1:0]          end_day,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [gdbd_pkg::COUNT_W-1:0] day_count,
	output logic [gdbd_pkg::STAT_W-1:0]         status
);

	logic include_end_day_q;

	gdbd_pkg::prep_t prep_a, prep_b, prep_a_s1, prep_b_s1;
	gdbd_pkg::dnum_t num_a, num_b, num_a_s2, num_b_s2;
	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	logic [gdbd_pkg::COUNT_W:0]   diff;
	logic [gdbd_pkg::COUNT_W-1:0] count_nx;
	logic [gdbd_pkg::STAT_W-1:0]  stat_nx;
	logic [gdbd_pkg::COUNT_W-1:0] count_s3;
	logic [gdbd_pkg::STAT_W-1:0]  stat_s3;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			include_end_day_q <= 1'b0;
		end else if (cfg_valid) begin
			include_end_day_q <= cfg_data;
		end
	end

	// a stage moves when it is empty or the next one moves
	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	gdbd_date_prep u_prep_a (
		.year  (start_year),
		.month (start_month),
		.day   (start_day),
		.prep  (prep_a)
	);

	gdbd_date_prep u_prep_b (
		.year  (end_year),
		.month (end_month),
		.day   (end_day),
		.prep  (prep_b)
	);

	gdbd_date_num u_num_a (
		.prep (prep_a_s1),
		.num  (num_a)
	);

	gdbd_date_num u_num_b (
		.prep (prep_b_s1),
		.num  (num_b)
	);

	always_comb begin
		diff = {1'b0, num_b_s2.dnum} - {1'b0, num_a_s2.dnum}
		     + (gdbd_pkg::COUNT_W+1)'(include_end_day_q);
		if (!(num_a_s2.ok && num_b_s2.ok)) begin
			count_nx = '0;
			stat_nx  = gdbd_pkg::STAT_INVALID;
		end else if (num_a_s2.dnum >= num_b_s2.dnum) begin
			count_nx = '1;
			stat_nx  = gdbd_pkg::STAT_ORDER;
		end else if (diff > (gdbd_pkg::COUNT_W+1)'(gdbd_pkg::COUNT_SAT)) begin
			count_nx = gdbd_pkg::COUNT_SAT;
			stat_nx  = gdbd_pkg::STAT_OK;
		end else begin
			count_nx = diff[gdbd_pkg::COUNT_W-1:0];
			stat_nx  = gdbd_pkg::STAT_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= in_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			prep_a_s1 <= prep_a;
			prep_b_s1 <= prep_b;
		end
		if (rdy2) begin
			num_a_s2 <= num_a;
			num_b_s2 <= num_b;
		end
		if (rdy3) begin
			count_s3 <= count_nx;
			stat_s3  <= stat_nx;
		end
	end

	assign out_valid = v_s3;
	assign day_count = count_s3;
	assign status    = stat_s3;

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == gdbd_pkg::STAT_INVALID) |-> (day_count == '0))
		else $error("invalid date beat with nonzero count");

	a_order_minus_one: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == gdbd_pkg::STAT_ORDER) |-> (day_count == '1))
		else $error("order beat without count of -1");

	a_ok_positive: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == gdbd_pkg::STAT_OK) |-> (day_count > 0))
		else $error("good beat with count not positive");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == gdbd_pkg::STAT_OK || status == gdbd_pkg::STAT_ORDER
		              || status == gdbd_pkg::STAT_INVALID))
		else $error("unused status code");

endmodule
